// ----- design/assert_macros.svh -----
// Assertion macros used by the checker module swk_checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Assert that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, cond, expr) \
    `ASSERT_CLK(lbl, (cond) |-> (expr))

`endif

// ----- design/swk_pkg.sv -----
// Types and constants for the swerve wheel kinematics block.
// No dependencies.
package swk_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VX,
        ST_VY,
        ST_CHECK,
        ST_ITER,
        ST_MAG_LO,
        ST_MAG_HI,
        ST_HEAD,
        ST_OUT
    } state_t;

    localparam logic [1:0] REG_TRACK_X  = 2'd0;
    localparam logic [1:0] REG_TRACK_Y  = 2'd1;
    localparam logic [1:0] REG_OFFSET_X = 2'd2;
    localparam logic [1:0] REG_OFFSET_Y = 2'd3;

    localparam logic [23:0] INV_GAIN = 24'd10188014;

    localparam logic signed [17:0] QUARTER_TURN  = 18'sd16384;
    localparam logic signed [17:0] HALF_TURN     = 18'sd32768;
    localparam logic signed [17:0] THREE_QUARTER = 18'sd49152;
    localparam logic signed [17:0] FULL_TURN     = 18'sd65536;

    localparam logic [31:0] ATAN_TAB [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ----- design/swerve_wheel_kinematics.sv -----
// Swerve drive inverse kinematics: one command in, four wheel results out.
// Depends on swk_pkg; one shared multiplier and one iterative CORDIC stage.
//
//   channel   handshake          payload
//   in        in_valid/in_ready  robot_vel_x/y, robot_turn_rate, now_angle_0..3
//   out       out_valid/out_ready wheel_index, wheel_speed, wheel_angle, flags
//   config    cfg_we             cfg_index, cfg_data
//
// Each wheel passes through forming the wheel vector (ST_VX, ST_VY, ST_CHECK), the
// CORDIC iterations, two magnitude multiplies, the heading and the output state;
// a zero wheel vector goes from ST_CHECK straight to the output state.
// One command runs the four wheels in turn, from wheel 0 to wheel 3.
// in_ready is high only when no command is in work. A stalled output holds
// the sequencer. Reset clears the state, the configuration and held angles to zero.
module swerve_wheel_kinematics
    import swk_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] robot_vel_x,
    input  logic signed [15:0] robot_vel_y,
    input  logic signed [15:0] robot_turn_rate,
    input  logic [15:0]        now_angle_0,
    input  logic [15:0]        now_angle_1,
    input  logic [15:0]        now_angle_2,
    input  logic [15:0]        now_angle_3,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         wheel_index,
    output logic signed [15:0] wheel_speed,
    output logic [15:0]        wheel_angle,
    output logic               angle_held,
    output logic               last_wheel
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

    state_t state_reg, state_next;

    logic [12:0]        track_x_reg, track_y_reg;
    logic [12:0]        offset_x_reg, offset_y_reg;
    logic [1:0]         wheel_reg, wheel_next;
    logic signed [15:0] rvx_reg, rvy_reg, rot_reg;
    logic [15:0]        now_reg [4];
    logic [15:0]        held_reg [4];
    logic signed [30:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [41:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [IW-1:0]      step_reg, step_next;
    logic [65:0]        acc_reg, acc_next;
    logic signed [15:0] speed_reg, speed_next;
    logic [15:0]        angle_reg, angle_next;
    logic               held_flag_reg, held_flag_next;
    logic               store_angle;

    logic signed [13:0] hx, hy, px, py;
    logic signed [24:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [46:0] mul_p;
    logic [40:0]        xpos;
    logic signed [30:0] ax, ay;
    logic signed [41:0] xs, ys;
    logic signed [33:0] atan_i;
    logic               y_pos, vec_zero;
    logic               vx_pos, vx_neg, vx_zero, vy_pos, vy_neg;
    logic [21:0]        mag_raw;
    logic [14:0]        mag;
    logic [32:0]        zc;
    logic [33:0]        tsum;
    logic [17:0]        t_raw;
    logic signed [17:0] t_s, now_s, a_base, a_flip, d;
    logic               flip;

    assign hx = $signed({2'b00, track_x_reg[12:1]}) - $signed({offset_x_reg[12], offset_x_reg});
    assign hy = $signed({2'b00, track_y_reg[12:1]}) - $signed({offset_y_reg[12], offset_y_reg});
    assign px = wheel_reg[0] ? hx : -hx;
    assign py = wheel_reg[1] ? -hy : hy;

    assign xpos  = x_reg[41] ? '0 : x_reg[40:0];
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (state_reg)
            ST_VX:
            begin
                mul_a = {{11{py[13]}}, py};
                mul_b = {{6{rot_reg[15]}}, rot_reg};
            end
            ST_VY:
            begin
                mul_a = {{11{px[13]}}, px};
                mul_b = {{6{rot_reg[15]}}, rot_reg};
            end
            ST_MAG_LO:
            begin
                mul_a = {1'b0, INV_GAIN};
                mul_b = {1'b0, xpos[20:0]};
            end
            ST_MAG_HI:
            begin
                mul_a = {1'b0, INV_GAIN};
                mul_b = {2'b00, xpos[40:21]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign ax       = vx_reg[30] ? -vx_reg : vx_reg;
    assign ay       = vy_reg[30] ? -vy_reg : vy_reg;
    assign vec_zero = (vx_reg == '0) && (vy_reg == '0);
    assign xs       = x_reg >>> step_reg;
    assign ys       = y_reg >>> step_reg;
    assign y_pos    = !y_reg[41] && (y_reg != '0);
    assign atan_i   = $signed({2'b00, ATAN_TAB[5'(step_reg)]});

    assign mag_raw = acc_reg[65:44];
    assign mag     = (mag_raw[21:15] != '0) ? 15'h7FFF : mag_raw[14:0];
    assign zc      = z_reg[33] ? '0 : z_reg[32:0];
    assign tsum    = {1'b0, zc} + 34'd32768;
    assign t_raw   = tsum[33:16];
    assign t_s     = (t_raw > 18'd16384) ? QUARTER_TURN : $signed(t_raw);
    assign now_s   = $signed({2'b00, now_reg[wheel_reg]});

    assign vx_zero = (vx_reg == '0);
    assign vx_neg  = vx_reg[30];
    assign vx_pos  = !vx_neg && !vx_zero;
    assign vy_neg  = vy_reg[30];
    assign vy_pos  = !vy_neg && (vy_reg != '0);

    always_comb
    begin
        a_base = '0;
        a_flip = '0;
        d      = '0;
        flip   = 1'b0;
        if (vx_pos && vy_pos)
        begin
            a_base = t_s;
            d      = now_s - a_base;
            flip   = (d > QUARTER_TURN) && (d < THREE_QUARTER);
            a_flip = a_base + HALF_TURN;
        end
        else if (vx_neg && vy_pos)
        begin
            a_base = HALF_TURN - t_s;
            d      = now_s - a_base;
            flip   = (d > QUARTER_TURN) || (d < -QUARTER_TURN);
            a_flip = a_base + HALF_TURN;
        end
        else if (vx_neg && vy_neg)
        begin
            a_base = HALF_TURN + t_s;
            d      = now_s - a_base;
            flip   = (d > QUARTER_TURN) || (d < -QUARTER_TURN);
            a_flip = a_base - HALF_TURN;
        end
        else if (vx_pos && vy_neg)
        begin
            a_base = FULL_TURN - t_s;
            d      = a_base - now_s;
            flip   = (d > QUARTER_TURN) && (d < THREE_QUARTER);
            a_flip = a_base - HALF_TURN;
        end
        else if (vx_zero && vy_pos)
        begin
            a_base = QUARTER_TURN;
            flip   = now_s > HALF_TURN;
            a_flip = THREE_QUARTER;
        end
        else if (vx_zero)
        begin
            a_base = THREE_QUARTER;
            flip   = now_s < HALF_TURN;
            a_flip = QUARTER_TURN;
        end
        else if (vx_pos)
        begin
            a_base = '0;
            flip   = (now_s > QUARTER_TURN) && (now_s < THREE_QUARTER);
            a_flip = HALF_TURN;
        end
        else
        begin
            a_base = HALF_TURN;
            flip   = (now_s < QUARTER_TURN) || (now_s > THREE_QUARTER);
            a_flip = '0;
        end
    end

    // next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = in_valid ? ST_VX : ST_IDLE;
            ST_VX:     state_next = ST_VY;
            ST_VY:     state_next = ST_CHECK;
            ST_CHECK:  state_next = vec_zero ? ST_OUT : ST_ITER;
            ST_ITER:   state_next = (step_reg == LAST_STEP) ? ST_MAG_LO : ST_ITER;
            ST_MAG_LO: state_next = ST_MAG_HI;
            ST_MAG_HI: state_next = ST_HEAD;
            ST_HEAD:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_ready)
                    state_next = ST_OUT;
                else if (wheel_reg == 2'd3)
                    state_next = ST_IDLE;
                else
                    state_next = ST_VX;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        wheel_next     = wheel_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        speed_next     = speed_reg;
        angle_next     = angle_reg;
        held_flag_next = held_flag_reg;
        store_angle    = 1'b0;
        case (state_reg)
            ST_IDLE:
                wheel_next = '0;
            ST_VX:
                vx_next = $signed({{3{rvx_reg[15]}}, rvx_reg, 12'd0}) - mul_p[30:0];
            ST_VY:
                vy_next = $signed({{3{rvy_reg[15]}}, rvy_reg, 12'd0}) + mul_p[30:0];
            ST_CHECK:
            begin
                x_next         = $signed({3'b000, ax, 8'd0});
                y_next         = $signed({3'b000, ay, 8'd0});
                z_next         = '0;
                step_next      = '0;
                speed_next     = '0;
                angle_next     = held_reg[wheel_reg];
                held_flag_next = 1'b1;
            end
            ST_ITER:
            begin
                if (y_pos)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_i;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_i;
                end
                step_next = step_reg + 1'b1;
            end
            ST_MAG_LO:
                acc_next = {21'd0, mul_p[44:0]};
            ST_MAG_HI:
                acc_next = acc_reg + {1'b0, mul_p[43:0], 21'd0} + (66'd1 << 43);
            ST_HEAD:
            begin
                speed_next     = flip ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                angle_next     = flip ? a_flip[15:0] : a_base[15:0];
                held_flag_next = 1'b0;
                store_angle    = 1'b1;
            end
            ST_OUT:
                if (out_ready)
                    wheel_next = wheel_reg + 1'b1;
            default:
                wheel_next = wheel_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wheel_reg    <= '0;
            track_x_reg  <= '0;
            track_y_reg  <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            for (int k = 0; k < 4; k++)
            begin
                held_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            wheel_reg <= wheel_next;
            if (store_angle)
                held_reg[wheel_reg] <= angle_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRACK_X:  track_x_reg  <= cfg_data;
                    REG_TRACK_Y:  track_y_reg  <= cfg_data;
                    REG_OFFSET_X: offset_x_reg <= cfg_data;
                    REG_OFFSET_Y: offset_y_reg <= cfg_data;
                    default:      track_x_reg  <= track_x_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rvx_reg    <= robot_vel_x;
            rvy_reg    <= robot_vel_y;
            rot_reg    <= robot_turn_rate;
            now_reg[0] <= now_angle_0;
            now_reg[1] <= now_angle_1;
            now_reg[2] <= now_angle_2;
            now_reg[3] <= now_angle_3;
        end
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        speed_reg     <= speed_next;
        angle_reg     <= angle_next;
        held_flag_reg <= held_flag_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign wheel_index = wheel_reg;
    assign wheel_speed = speed_reg;
    assign wheel_angle = angle_reg;
    assign angle_held  = held_flag_reg;
    assign last_wheel  = (wheel_reg == 2'd3);

endmodule

// ----- design/swk_checker.sv -----
// Port-level checks for swerve_wheel_kinematics, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module swk_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_we,
    input logic [1:0]         cfg_index,
    input logic [12:0]        cfg_data,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [15:0] robot_vel_x,
    input logic signed [15:0] robot_vel_y,
    input logic signed [15:0] robot_turn_rate,
    input logic [15:0]        now_angle_0,
    input logic [15:0]        now_angle_1,
    input logic [15:0]        now_angle_2,
    input logic [15:0]        now_angle_3,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         wheel_index,
    input logic signed [15:0] wheel_speed,
    input logic [15:0]        wheel_angle,
    input logic               angle_held,
    input logic               last_wheel
);

    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(wheel_angle))
    `ASSERT_IMPLY(a_idle_accept, in_valid && in_ready, !out_valid)
    `ASSERT_IMPLY(a_held_zero, out_valid && angle_held, wheel_speed == 16'sd0)
    `ASSERT_IMPLY(a_last_idx, out_valid && last_wheel, wheel_index == 2'd3)
    `ASSERT_CLK(a_mid_busy, out_valid && out_ready && !last_wheel |=> !in_ready)

endmodule

bind swerve_wheel_kinematics swk_checker u_swk_checker (.*);
